FILE: design/mrc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the
// Modbus RTU response checker. No dependencies.
`timescale 1ns / 1ps

package mrc_pkg;

  // Frame limits and derived widths
  localparam int MAX_FRAME_BYTES = 256;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W           = (POS_W > 9) ? POS_W : 9;
  localparam int MAX_REGS        = 125;
  localparam int MIN_LEN         = 5;
  localparam int HDR_LEN         = 5;
  localparam int ECHO_LEN        = 8;

  localparam logic [6:0]  FC_READ  = 7'd3;
  localparam logic [7:0]  EXC_FLAG = 8'h80;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_FUNCTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARSE_MODE        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_COUNT    = 2'd3;

  localparam logic MODE_READ = 1'b0;
  localparam logic MODE_ECHO = 1'b1;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_CRC_ERR   = 2'd2,
    ST_EXCEPTION = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] node_address;
    logic [6:0] expected_function;
    logic       parse_mode;
    logic [6:0] register_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } item_t;

  // Handshake between the input register and the parser
  typedef struct packed {
    logic  go;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic        result_kind;
    logic [6:0]  reg_index;
    logic [15:0] reg_value;
    status_t     frame_status;
    logic [7:0]  exception_code;
  } result_t;

  // One byte of CRC-16/MODBUS, reflected, eight shift steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/modbus_response_checker.sv
// Top level of the Modbus RTU response checker: config registers, input
// register, parser and result register. Depends on mrc_pkg and mrc_* modules.
//
//   channel | direction | tdata                         | tuser       | tlast
//   --------+-----------+-------------------------------+-------------+----------
//   in_     | slave     | rx_byte                       | -           | frame_end
//   out_    | master    | index, value, status, exc code| result_kind | -
//   cfg_    | slave     | cfg_index + cfg_data (8 bits) | -           | -
//
// One byte per cycle sustained unless out_tready holds off a waiting result;
// a byte waits in the input register, its result goes to the result register.
// The byte-wide CRC update and the status compare chain sit between those two.
// Synchronous active-low reset clears control state and loads register defaults.
// While a result waits, one more byte is still taken into the input register.
`timescale 1ns / 1ps

module modbus_response_checker import mrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  logic                 in_tlast,   // frame_end
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // [6:0] reg_index, [22:7] reg_value,
                                           // [24:23] frame_status,
                                           // [32:25] exception_code, [39:33] zero
  output logic                 out_tuser,  // result_kind
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  stage_t  stage;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.rx_byte   = in_tdata;
  assign in_item.frame_end = in_tlast;

  mrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mrc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .out_free  (out_free),
    .stage     (stage)
  );

  mrc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  mrc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (stage.go & res_valid),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // Output word packing
  assign out_tuser = out_res.result_kind;
  assign out_tdata = {7'd0, out_res.exception_code, out_res.frame_status,
                      out_res.reg_value, out_res.reg_index};

  // A value word never carries status or exception code
  a_value_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_VALUE) |-> (out_tdata[32:23] == 10'd0))
    else $error("value word with status bits set");

  // A status word never carries index or value
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_STATUS) |-> (out_tdata[22:0] == 23'd0))
    else $error("status word with register payload");

  // An exception code only comes with an exception status
  a_exc_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32:25] != 8'd0) |-> (out_tdata[24:23] == ST_EXCEPTION))
    else $error("exception code without exception status");

  // Value words are only produced in read mode
  a_value_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_VALUE) |-> (cfg.parse_mode == MODE_READ))
    else $error("value word outside read mode");

endmodule

FILE: design/mrc_cfg_regs.sv
// Configuration register file for the Modbus RTU response checker.
// Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_cfg_regs import mrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_NODE_ADDRESS:      cfg_nxt.node_address      = cfg_data;
        CFG_EXPECTED_FUNCTION: cfg_nxt.expected_function = cfg_data[6:0];
        CFG_PARSE_MODE:        cfg_nxt.parse_mode        = cfg_data[0];
        CFG_REGISTER_COUNT:    cfg_nxt.register_count    = cfg_data[6:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_address      <= 8'd1;
      cfg_r.expected_function <= FC_READ;
      cfg_r.parse_mode        <= MODE_READ;
      cfg_r.register_count    <= 7'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: design/mrc_in_stage.sv
// Input register for received bytes; releases a word to the parser when
// the result register can take its outcome. Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_in_stage import mrc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_tvalid,
  output logic   in_tready,
  input  item_t  in_item,
  input  logic   out_free,
  output stage_t stage
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  take;
  logic  go;

  assign go        = valid_r & out_free;
  assign in_tready = ~valid_r | out_free;
  assign take      = in_tvalid & in_tready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (take) begin
      valid_nxt = 1'b1;
      item_nxt  = in_item;
    end else if (go) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign stage.go    = go;
  assign stage.item  = item_r;

endmodule

FILE: design/mrc_parser.sv
// Per-frame parse state, CRC, register value capture and final status check.
// Depends on mrc_pkg (types, constants, crc_feed).
`timescale 1ns / 1ps

module mrc_parser import mrc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  stage_t  stage,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             node_r, node_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       third_r, third_nxt;
  logic [7:0]       high_r, high_nxt;

  logic [7:0]       b;
  logic             last;
  logic             in_range;
  logic [POS_W-1:0] pos_m4;
  logic [POS_W-2:0] k;
  logic [6:0]       lim;
  logic [6:0]       fc;
  logic [CMP_W-1:0] n_len;
  logic [CMP_W-1:0] exp_len;
  status_t          st;
  logic [7:0]       exc;

  assign b        = stage.item.rx_byte;
  assign last     = stage.item.frame_end;
  assign in_range = pos_r < POS_W'(MAX_FRAME_BYTES);
  assign pos_m4   = pos_r - POS_W'(4);
  assign k        = pos_m4[POS_W-1:1];
  assign lim      = (cfg.register_count > 7'(MAX_REGS)) ? 7'(MAX_REGS) : cfg.register_count;
  assign fc       = (cfg.parse_mode == MODE_ECHO) ? cfg.expected_function : FC_READ;

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_feed(crc_r, b);
    node_nxt  = node_r;
    func_nxt  = func_r;
    third_nxt = third_r;
    high_nxt  = high_r;
    res_valid = 1'b0;
    res       = '0;
    st        = ST_OK;
    exc       = 8'h00;
    n_len     = '0;
    exp_len   = '0;

    // Byte capture by position
    if (in_range) begin
      if (pos_r == POS_W'(0)) begin
        node_nxt = (b == cfg.node_address);
      end else if (pos_r == POS_W'(1)) begin
        func_nxt = b;
      end else if (pos_r == POS_W'(2)) begin
        third_nxt = b;
      end else if (pos_r[0]) begin
        high_nxt = b;
      end else if (!last && cfg.parse_mode == MODE_READ) begin
        if (CMP_W'(k) < CMP_W'(lim)) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_VALUE;
          res.reg_index   = k[6:0];
          res.reg_value   = {high_r, b};
        end
      end
      pos_nxt = pos_r + POS_W'(1);
    end

    // Final status on the last byte, then rearm
    if (last) begin
      n_len   = CMP_W'(pos_nxt);
      exp_len = CMP_W'(HDR_LEN) + CMP_W'({cfg.register_count, 1'b0});
      if (n_len < CMP_W'(MIN_LEN)) begin
        st = ST_MALFORMED;
      end else if (crc_nxt != 16'h0000) begin
        st = ST_CRC_ERR;
      end else if (!node_nxt) begin
        st = ST_MALFORMED;
      end else if (func_nxt == (EXC_FLAG | {1'b0, fc})) begin
        st  = ST_EXCEPTION;
        exc = third_nxt;
      end else if (func_nxt != {1'b0, fc}) begin
        st = ST_MALFORMED;
      end else if (cfg.parse_mode == MODE_READ) begin
        if (n_len != exp_len || third_nxt != {cfg.register_count, 1'b0}) begin
          st = ST_MALFORMED;
        end
      end else if (n_len != CMP_W'(ECHO_LEN)) begin
        st = ST_MALFORMED;
      end
      res_valid          = 1'b1;
      res                = '0;
      res.result_kind    = KIND_STATUS;
      res.frame_status   = st;
      res.exception_code = exc;
      pos_nxt            = '0;
      crc_nxt            = CRC_INIT;
      node_nxt           = 1'b0;
      func_nxt           = 8'h00;
      third_nxt          = 8'h00;
      high_nxt           = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      crc_r   <= CRC_INIT;
      node_r  <= 1'b0;
      func_r  <= 8'h00;
      third_r <= 8'h00;
      high_r  <= 8'h00;
    end else if (stage.go) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      node_r  <= node_nxt;
      func_r  <= func_nxt;
      third_r <= third_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

FILE: design/mrc_out_reg.sv
// Result register: holds one result word until the consumer takes it.
// Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_out_reg import mrc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    out_free,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign out_free   = ~valid_r | out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
